/* design/sleep_timer_queue_assert.svh */
// Assertion macros shared by the checker
`ifndef SLEEP_TIMER_QUEUE_ASSERT_SVH
`define SLEEP_TIMER_QUEUE_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define STQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

/* design/stq_pkg.sv */
`default_nettype none
package stq_pkg;
  localparam int unsigned TASK_SLOTS_DEF = 16;
  localparam int unsigned RESULT_CAP = 16;
  localparam int unsigned OP_W = 3;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned AMT_W = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADVANCE = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_CANCEL = 3'd2,
    OP_POP = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  // Word passed from front to back
  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [SLOT_W-1:0] task_slot;
    logic [AMT_W-1:0] amount;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_SINGLE
  } state_t;

  // Result word towards output register
  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic ok;
    logic [TIME_W-1:0] time_value;
    logic last;
  } res_t;
endpackage
`default_nettype wire

/* design/stq_front.sv */
`default_nettype none
// Input acceptance and a short command queue
module stq_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire stq_pkg::cmd_t in_cmd,
  output logic q_valid,
  input  wire logic q_ready,
  output stq_pkg::cmd_t q_cmd
);
  stq_pkg::cmd_t mem [stq_pkg::QDEPTH];
  logic wptr, rptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_cmd;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* design/stq_back.sv */
`default_nettype none
// Executes commands; pop and query walk slots one per cycle to find the earliest
module stq_back #(
  parameter int unsigned TASK_SLOTS = stq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire stq_pkg::cmd_t q_cmd,
  output logic out_valid,
  input  wire logic out_ready,
  output stq_pkg::res_t out_res
);
  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned NW = $clog2(stq_pkg::RESULT_CAP + 1);

  stq_pkg::state_t state, state_next;
  logic [stq_pkg::TIME_W-1:0] current_time, next_stamp;
  logic [TASK_SLOTS-1:0] armed;
  logic [stq_pkg::TIME_W-1:0] wake [TASK_SLOTS];
  logic [stq_pkg::TIME_W-1:0] stamp [TASK_SLOTS];
  stq_pkg::cmd_t cmd;
  logic [CW-1:0] scan;
  logic [IW-1:0] scan_idx;
  logic best_found;
  logic [IW-1:0] best_idx;
  logic [stq_pkg::TIME_W-1:0] best_wake, best_stamp;
  logic [NW-1:0] emitted;
  logic in_range;
  logic [IW-1:0] cslot;
  logic better;
  logic due;
  logic take_new;
  logic out_free;
  logic out_load;
  logic hold_valid;
  logic [IW-1:0] hold_slot;
  stq_pkg::res_t res_single;
  stq_pkg::res_t res_load;

  assign out_free = !out_valid || out_ready;
  assign scan_idx = scan[IW-1:0];
  assign in_range = {{(32-stq_pkg::SLOT_W){1'b0}}, cmd.task_slot} < TASK_SLOTS;
  assign cslot = IW'(cmd.task_slot);
  assign better = armed[scan_idx] && (!best_found || wake[scan_idx] < best_wake ||
    (wake[scan_idx] == best_wake && stamp[scan_idx] < best_stamp));
  assign due = best_found && (best_wake <= current_time);
  assign take_new = due && (emitted != NW'(stq_pkg::RESULT_CAP));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      stq_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.operation == stq_pkg::OP_POP || q_cmd.operation == stq_pkg::OP_QUERY)
            state_next = stq_pkg::ST_SEARCH;
          else
            state_next = stq_pkg::ST_SINGLE;
        end
      end
      stq_pkg::ST_SEARCH: begin
        if (scan == CW'(TASK_SLOTS)) begin
          if (cmd.operation == stq_pkg::OP_POP) state_next = stq_pkg::ST_EMIT;
          else state_next = stq_pkg::ST_SINGLE;
        end
      end
      stq_pkg::ST_EMIT: if (out_free) begin
        if (take_new) state_next = stq_pkg::ST_SEARCH;
        else state_next = stq_pkg::ST_IDLE;
      end
      stq_pkg::ST_SINGLE: if (out_free) state_next = stq_pkg::ST_IDLE;
      default: state_next = stq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_ready = (state == stq_pkg::ST_IDLE);
    res_single = '0;
    res_single.last = 1'b1;
    case (cmd.operation)
      stq_pkg::OP_ADVANCE: begin
        res_single.ok = 1'b1;
        res_single.time_value = current_time + {32'd0, cmd.amount};
      end
      stq_pkg::OP_SCHEDULE: res_single.ok = in_range && !armed[cslot];
      stq_pkg::OP_CANCEL: res_single.ok = in_range && armed[cslot];
      stq_pkg::OP_QUERY: begin
        res_single.ok = best_found;
        res_single.time_value = best_found ? best_wake : '0;
      end
      default: ;
    endcase
    out_load = 1'b0;
    res_load = res_single;
    unique case (state)
      // Send held slot once next search shows if run ends; none held or due: ok=0
      stq_pkg::ST_EMIT: begin
        out_load = out_free && (hold_valid || !take_new);
        res_load = '0;
        res_load.last = 1'b1;
        if (hold_valid) begin
          res_load.result_slot = stq_pkg::SLOT_W'(hold_slot);
          res_load.ok = 1'b1;
          res_load.last = !take_new;
        end
      end
      stq_pkg::ST_SINGLE: out_load = out_free;
      default: ;
    endcase
  end

  // Sequencer state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::ST_IDLE;
      current_time <= '0;
      next_stamp <= '0;
      armed <= '0;
      out_valid <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        out_res <= res_load;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        stq_pkg::ST_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          scan <= '0;
          best_found <= 1'b0;
          emitted <= '0;
        end
        stq_pkg::ST_SEARCH: begin
          if (scan != CW'(TASK_SLOTS)) begin
            if (better) begin
              best_found <= 1'b1;
              best_idx <= scan_idx;
              best_wake <= wake[scan_idx];
              best_stamp <= stamp[scan_idx];
            end
            scan <= scan + 1'b1;
          end
        end
        stq_pkg::ST_EMIT: if (out_free) begin
          if (take_new) begin
            // Disarm the due slot and hold it back until the run end is known
            armed[best_idx] <= 1'b0;
            hold_slot <= best_idx;
            hold_valid <= 1'b1;
            emitted <= emitted + 1'b1;
          end else begin
            hold_valid <= 1'b0;
          end
          scan <= '0;
          best_found <= 1'b0;
        end
        stq_pkg::ST_SINGLE: if (out_free) begin
          if (cmd.operation == stq_pkg::OP_ADVANCE) current_time <= res_single.time_value;
          if (cmd.operation == stq_pkg::OP_SCHEDULE && res_single.ok) begin
            armed[cslot] <= 1'b1;
            next_stamp <= next_stamp + 1'b1;
          end
          if (cmd.operation == stq_pkg::OP_CANCEL && res_single.ok) armed[cslot] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Slot table write
  always_ff @(posedge clk) begin
    if (state == stq_pkg::ST_SINGLE && out_free && cmd.operation == stq_pkg::OP_SCHEDULE
        && res_single.ok) begin
      wake[cslot] <= current_time + {32'd0, cmd.amount};
      stamp[cslot] <= next_stamp;
    end
  end
endmodule
`default_nettype wire

/* design/sleep_timer_queue.sv */
// Advance, schedule, cancel and unknown codes go through the single-op state; a query and
// a pop first search every slot, one per cycle.
// Pop due: each due slot is found by a full search and held back by one slot of
// look-ahead, so tlast can be set on the last one.
// The back end takes a new command only when idle; the front queue holds up to two words.
// Synchronous active-high reset clears time, stamp counter and armed bits.
`default_nettype none
module sleep_timer_queue #(
  parameter int unsigned TASK_SLOTS = stq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // [2:0] operation, [6:3] task_slot, [38:7] amount, [39] zero
  input  wire logic [39:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // [3:0] result_slot, [4] ok, [68:5] time_value, [71:69] zero
  output logic [71:0] m_tdata,
  output logic m_tlast
);
  stq_pkg::cmd_t in_cmd, q_cmd;
  stq_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_cmd.operation = s_tdata[2:0];
  assign in_cmd.task_slot = s_tdata[6:3];
  assign in_cmd.amount = s_tdata[38:7];
  assign m_tdata = {3'd0, res.time_value, res.ok, res.result_slot};
  assign m_tlast = res.last;

  // Front: accept and queue
  stq_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  // Back: execute
  stq_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );
endmodule
`default_nettype wire

/* design/stq_checker.sv */
`default_nettype none
`include "sleep_timer_queue_assert.svh"
// Port-level checks
module stq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic m_tlast
);
  `STQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `STQ_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[71:69] == 3'd0)
  `STQ_ASSERT_IMP(a_miss_last, m_tvalid && !m_tdata[4], m_tlast)
  `STQ_ASSERT_IMP(a_slot_time, m_tvalid && m_tdata[3:0] != 4'd0, m_tdata[68:5] == 64'd0)
  `STQ_ASSERT_IMP(a_in_ready_known, s_tvalid, !$isunknown(s_tready))
endmodule
bind sleep_timer_queue stq_checker u_chk (.*);
`default_nettype wire
